// ===== rtl/twik_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the tendon wire length IK block.
// No dependencies; every other file refers to this package by scoped names.
package twik_pkg;

	localparam int unsigned MAX_JOINT_PAIRS = 16;

	localparam int unsigned ANG_W   = 17;
	localparam int unsigned LEN_W   = 24;
	localparam int unsigned COS_W   = 32;
	localparam int unsigned TH_W    = 33;
	localparam int unsigned ARG_W   = 34;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;

	// joint pair count and its table index
	localparam int unsigned NW      = $clog2(MAX_JOINT_PAIRS + 1);
	localparam int unsigned JP_IW   = (MAX_JOINT_PAIRS > 1) ? $clog2(MAX_JOINT_PAIRS) : 1;
	localparam int unsigned SCALE_W = 21 + NW;

	// reciprocal of n for the half-angle division, exact for 32-bit dividends
	localparam int unsigned RECIP_SH = 32 + JP_IW;
	localparam int unsigned RECIP_W  = RECIP_SH + 1;
	localparam int unsigned RECIP_HW = RECIP_W - 32;

	typedef logic [RECIP_W-1:0] recip_arr_t [MAX_JOINT_PAIRS];

	function automatic recip_arr_t recip_table();
		recip_arr_t r;
		for (int i = 0; i < int'(MAX_JOINT_PAIRS); i++) begin
			r[i] = RECIP_W'(((72'd1 << RECIP_SH) + 72'(i)) / 72'(i + 1));
		end
		return r;
	endfunction

	localparam recip_arr_t RECIP = recip_table();

	// fixed-point constants, Q30 radians
	localparam logic [30:0] DEG8_TO_RAD36 = 31'd1199381129;
	localparam logic [32:0] PI_Q30        = 33'd3373259426;
	localparam logic [32:0] HALF_PI_Q30   = 33'd1686629713;
	localparam logic [32:0] TWO_PI_Q30    = 33'd6746518852;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	// Horner steps of the cosine series
	localparam int unsigned HSTEPS = 6;
	typedef logic [7:0]  hdiv_arr_t [HSTEPS];
	typedef int unsigned hk_arr_t   [HSTEPS];
	typedef logic [31:0] hm_arr_t   [HSTEPS];

	localparam hdiv_arr_t HDIV = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

	function automatic hk_arr_t hk_table();
		hk_arr_t r;
		for (int i = 0; i < int'(HSTEPS); i++) begin
			r[i] = 31 + $clog2(HDIV[i]);
		end
		return r;
	endfunction

	localparam hk_arr_t HK = hk_table();

	function automatic hm_arr_t hm_table();
		hm_arr_t r;
		for (int i = 0; i < int'(HSTEPS); i++) begin
			r[i] = 32'((64'd1 << HK[i]) / 64'(HDIV[i]));
		end
		return r;
	endfunction

	localparam hm_arr_t HM = hm_table();

	// pipeline timing
	localparam int unsigned ANGLE_LAT  = 4;
	localparam int unsigned COS_LAT    = 3 + 3 * HSTEPS;
	localparam int unsigned WIRE_LAT   = 3;
	localparam int unsigned PIPE_DEPTH = ANGLE_LAT + COS_LAT + WIRE_LAT;
	localparam int unsigned GRIP_LAT   = 3;
	localparam int unsigned GRIP_DLY   = PIPE_DEPTH - GRIP_LAT;

	// register map
	typedef enum logic [2:0] {
		REG_BEND_LIMIT  = 3'd0,
		REG_JOINT_PAIRS = 3'd1,
		REG_SEGMENT_ARC = 3'd2,
		REG_WIRE_ANGLE  = 3'd3,
		REG_FORCEPS_MAX = 3'd4,
		REG_GRIP_GAIN   = 3'd5
	} reg_idx_t;

	localparam logic [15:0] RST_BEND_LIMIT  = 16'd23040;
	localparam logic [4:0]  RST_JOINT_PAIRS = 5'd1;
	localparam logic [19:0] RST_SEGMENT_ARC = 20'd65536;
	localparam logic [16:0] RST_WIRE_ANGLE  = 17'd0;
	localparam logic [15:0] RST_FORCEPS_MAX = 16'd7680;
	localparam logic [15:0] RST_GRIP_GAIN   = 16'd0;

	localparam logic [63:0] OUT_MAX     = 64'd8388607;
	localparam logic [63:0] OUT_MIN_MAG = 64'd8388608;

	// shift right with round half away from zero, then saturate to 24 bits
	function automatic logic signed [LEN_W-1:0] rnd_sat(input logic signed [63:0] v,
		input int unsigned sh);
		logic        neg;
		logic [63:0] m;
		neg = v[63];
		m = neg ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		if (neg) begin
			if (m > OUT_MIN_MAG) m = OUT_MIN_MAG;
			m = 64'd0 - m;
		end else begin
			if (m > OUT_MAX) m = OUT_MAX;
		end
		return LEN_W'(m);
	endfunction

endpackage

// ===== rtl/twik_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the angle requests and the length results.
// Depends on twik_pkg for field widths.
interface twik_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [twik_pkg::ANG_W-1:0]    pan_angle;
	logic signed [twik_pkg::ANG_W-1:0]    tilt_angle;
	logic signed [twik_pkg::ANG_W-1:0]    grip_angle;

	modport source (output valid, output pan_angle, output tilt_angle, output grip_angle,
		input ready);
	modport sink (input valid, input pan_angle, input tilt_angle, input grip_angle,
		output ready);
endinterface

interface twik_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [twik_pkg::LEN_W-1:0]    east_length;
	logic signed [twik_pkg::LEN_W-1:0]    west_length;
	logic signed [twik_pkg::LEN_W-1:0]    south_length;
	logic signed [twik_pkg::LEN_W-1:0]    north_length;
	logic signed [twik_pkg::LEN_W-1:0]    grip_length;

	modport source (output valid, output east_length, output west_length,
		output south_length, output north_length, output grip_length, input ready);
	modport sink (input valid, input east_length, input west_length,
		input south_length, input north_length, input grip_length, output ready);
endinterface

// ===== rtl/twik_angle.sv =====
`timescale 1ns / 1ps
// Clamp one bend angle and convert it to the per-joint half angle, Q30 radians.
// Four stages; depends on twik_pkg.
module twik_angle (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [twik_pkg::ANG_W-1:0]   angle,
	input  logic [15:0]                         bend_limit,
	input  logic [twik_pkg::JP_IW-1:0]          n_idx,
	output logic signed [twik_pkg::TH_W-1:0]    th
);
	logic [16:0]                          amag;
	logic [15:0]                          mag_s1;
	logic                                 neg_s1;
	logic [46:0]                          prod_s2;
	logic                                 neg_s2;
	logic [63:0]                          pl_s3;
	logic [31+twik_pkg::RECIP_HW:0]       ph_s3;
	logic                                 neg_s3;
	logic signed [twik_pkg::TH_W-1:0]     th_s4;
	logic [31:0]                          x;
	logic [twik_pkg::RECIP_W-1:0]         recip;
	logic [63+twik_pkg::RECIP_HW:0]       full;
	logic [31:0]                          q;

	assign amag  = angle[16] ? 17'(-angle) : 17'(angle);
	assign x     = prod_s2[46:15];
	assign recip = twik_pkg::RECIP[n_idx];
	assign full  = {ph_s3, 32'd0} + (64 + twik_pkg::RECIP_HW)'(pl_s3);
	assign q     = full[twik_pkg::RECIP_SH +: 32];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= (amag > {1'b0, bend_limit}) ? bend_limit : amag[15:0];
			neg_s1  <= angle[16];
			prod_s2 <= 47'(mag_s1) * 47'(twik_pkg::DEG8_TO_RAD36);
			neg_s2  <= neg_s1;
			pl_s3   <= 64'(x) * 64'(recip[31:0]);
			ph_s3   <= (32 + twik_pkg::RECIP_HW)'(x) *
				(32 + twik_pkg::RECIP_HW)'(recip[twik_pkg::RECIP_W-1:32]);
			neg_s3  <= neg_s2;
			th_s4   <= neg_s3 ? -signed'({1'b0, q}) : signed'({1'b0, q});
		end
	end

	assign th = th_s4;
endmodule

// ===== rtl/twik_cos.sv =====
`timescale 1ns / 1ps
// Pipelined Q30 cosine: magnitude, quadrant fold, square, six Horner steps.
// Each Horner step takes three stages; depends on twik_pkg.
module twik_cos (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [twik_pkg::ARG_W-1:0]   arg,
	output logic signed [twik_pkg::COS_W-1:0]   cos_val
);
	localparam int unsigned HS = twik_pkg::HSTEPS;

	logic [32:0]          u_s1;
	logic [30:0]          u_s2;
	logic                 neg_s2;
	logic [61:0]          sq_s3;
	logic                 neg_s3;
	logic [32:0]          v1;
	logic [32:0]          v2;
	logic                 fneg;

	logic signed [31:0]   horn_t   [HS+1];
	logic [31:0]          horn_x2  [HS+1];
	logic                 horn_neg [HS+1];

	// fold into the first quadrant, the argument stays below two pi
	assign v1   = (u_s1 > twik_pkg::PI_Q30) ? twik_pkg::TWO_PI_Q30 - u_s1 : u_s1;
	assign fneg = v1 > twik_pkg::HALF_PI_Q30;
	assign v2   = fneg ? twik_pkg::PI_Q30 - v1 : v1;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= arg[twik_pkg::ARG_W-1] ? 33'(-arg) : 33'(arg);
			u_s2   <= v2[30:0];
			neg_s2 <= fneg;
			sq_s3  <= 62'(u_s2) * 62'(u_s2);
			neg_s3 <= neg_s2;
		end
	end

	assign horn_t[0]   = twik_pkg::ONE_Q30;
	assign horn_x2[0]  = sq_s3[61:30];
	assign horn_neg[0] = neg_s3;

	for (genvar g = 0; g < HS; g++) begin : g_step
		logic [30:0] tt;
		logic [62:0] prod;
		logic [31:0] p_s1;
		logic [31:0] x2_s1;
		logic        neg_s1;
		logic [63:0] pm_s2;
		logic [31:0] p_s2;
		logic [31:0] x2_s2;
		logic        neg_s2;
		logic signed [31:0] t_s3;
		logic [31:0] x2_s3;
		logic        neg_s3;
		logic [31:0] q0;
		logic [39:0] r;
		logic [31:0] q;

		assign tt   = horn_t[g][31] ? 31'd0 : horn_t[g][30:0];
		assign prod = 63'(horn_x2[g]) * 63'(tt);
		assign q0   = 32'(pm_s2 >> twik_pkg::HK[g]);
		assign r    = 40'(p_s2) - 40'(q0) * 40'(twik_pkg::HDIV[g]);
		// the reciprocal estimate is at most one short
		assign q    = (r >= 40'(twik_pkg::HDIV[g])) ? q0 + 32'd1 : q0;

		always_ff @(posedge clk) begin
			if (en) begin
				p_s1   <= prod[61:30];
				x2_s1  <= horn_x2[g];
				neg_s1 <= horn_neg[g];
				pm_s2  <= 64'(p_s1) * 64'(twik_pkg::HM[g]);
				p_s2   <= p_s1;
				x2_s2  <= x2_s1;
				neg_s2 <= neg_s1;
				t_s3   <= twik_pkg::ONE_Q30 - signed'(q);
				x2_s3  <= x2_s2;
				neg_s3 <= neg_s2;
			end
		end

		assign horn_t[g+1]   = t_s3;
		assign horn_x2[g+1]  = x2_s3;
		assign horn_neg[g+1] = neg_s3;
	end

	assign cos_val = horn_neg[HS] ? -horn_t[HS] : horn_t[HS];
endmodule

// ===== rtl/twik_wire.sv =====
`timescale 1ns / 1ps
// One wire length: cosine bracket, scale by 2*R*n, round and saturate.
// Three stages; depends on twik_pkg.
module twik_wire (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [twik_pkg::COS_W-1:0]   cos_a,
	input  logic signed [twik_pkg::COS_W-1:0]   cos_main,
	input  logic signed [twik_pkg::COS_W-1:0]   cos_cross,
	input  logic [twik_pkg::SCALE_W-1:0]        scale,
	output logic signed [twik_pkg::LEN_W-1:0]   len
);
	logic signed [34:0]                       d_s1;
	logic signed [35+twik_pkg::SCALE_W:0]     prod_s2;
	logic signed [twik_pkg::LEN_W-1:0]        len_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= 35'(cos_a) - 35'(cos_main) + 35'(twik_pkg::ONE_Q30) - 35'(cos_cross);
			prod_s2 <= (36 + twik_pkg::SCALE_W)'(d_s1) *
				(36 + twik_pkg::SCALE_W)'(signed'({1'b0, scale}));
			len_s3  <= twik_pkg::rnd_sat(64'(prod_s2), 30);
		end
	end

	assign len = len_s3;
endmodule

// ===== rtl/tendon_wire_length_ik_top.sv =====
`timescale 1ns / 1ps
// Accepts one request per cycle whenever the output slot is free or being taken.
// Throughput: one result per cycle; the whole pipeline holds when the output is full
// and not taken, so the output register doubles as the skid stage.
// Reset: arst_n clears valid bits and loads register defaults; payload is not reset.
// Depends on twik_pkg, twik_if, twik_angle, twik_cos and twik_wire.
module tendon_wire_length_ik_top (
	input  logic                              clk,
	input  logic                              arst_n,
	twik_in_if.sink                           in_ch,
	twik_out_if.source                        out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [twik_pkg::ADDR_W-1:0]       paddr,
	input  logic [twik_pkg::DATA_W-1:0]       pwdata,
	output logic [twik_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);
	logic [15:0] bend_limit_q;
	logic [4:0]  joint_pairs_q;
	logic [19:0] segment_arc_q;
	logic [16:0] wire_angle_q;
	logic [15:0] forceps_max_q;
	logic [15:0] grip_gain_q;

	logic                               wr;
	twik_pkg::reg_idx_t                 widx;
	logic [twik_pkg::JP_IW-1:0]         n_idx;
	logic [twik_pkg::NW-1:0]            n_val;
	logic [twik_pkg::SCALE_W-1:0]       scale_q;
	logic                               en;
	logic [twik_pkg::PIPE_DEPTH-1:0]    vld_q;

	logic signed [twik_pkg::TH_W-1:0]   th_p;
	logic signed [twik_pkg::TH_W-1:0]   th_t;
	logic signed [twik_pkg::ARG_W-1:0]  alpha;
	logic signed [twik_pkg::COS_W-1:0]  c_a, c_e, c_w, c_s, c_n, c_p, c_t;

	logic signed [17:0]                 gdiff_s1;
	logic signed [34:0]                 gprod_s2;
	logic signed [twik_pkg::LEN_W-1:0]  grip_s3;
	logic signed [twik_pkg::LEN_W-1:0]  grip_dly [twik_pkg::GRIP_DLY];

	// register file: written in the access phase, pready tied high
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign widx   = twik_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bend_limit_q  <= twik_pkg::RST_BEND_LIMIT;
			joint_pairs_q <= twik_pkg::RST_JOINT_PAIRS;
			segment_arc_q <= twik_pkg::RST_SEGMENT_ARC;
			wire_angle_q  <= twik_pkg::RST_WIRE_ANGLE;
			forceps_max_q <= twik_pkg::RST_FORCEPS_MAX;
			grip_gain_q   <= twik_pkg::RST_GRIP_GAIN;
		end else if (wr) begin
			case (widx)
				twik_pkg::REG_BEND_LIMIT:  bend_limit_q  <= pwdata[15:0];
				twik_pkg::REG_JOINT_PAIRS: joint_pairs_q <= pwdata[4:0];
				twik_pkg::REG_SEGMENT_ARC: segment_arc_q <= pwdata[19:0];
				twik_pkg::REG_WIRE_ANGLE:  wire_angle_q  <= pwdata[16:0];
				twik_pkg::REG_FORCEPS_MAX: forceps_max_q <= pwdata[15:0];
				twik_pkg::REG_GRIP_GAIN:   grip_gain_q   <= pwdata[15:0];
				default: ;  // drop writes past the map
			endcase
		end
	end

	always_comb begin
		case (widx)
			twik_pkg::REG_BEND_LIMIT:  prdata = 32'(bend_limit_q);
			twik_pkg::REG_JOINT_PAIRS: prdata = 32'(joint_pairs_q);
			twik_pkg::REG_SEGMENT_ARC: prdata = 32'(segment_arc_q);
			twik_pkg::REG_WIRE_ANGLE:  prdata = 32'(wire_angle_q);
			twik_pkg::REG_FORCEPS_MAX: prdata = 32'(forceps_max_q);
			twik_pkg::REG_GRIP_GAIN:   prdata = 32'(grip_gain_q);
			default:                   prdata = '0;
		endcase
	end

	// Joint pair count: zero acts as one, large counts stop at the table size.
	// The user must change configuration only with the pipeline empty; the block does not
	// enforce this, and stages read the registers directly instead of carrying copies.
	always_comb begin
		if (joint_pairs_q == 5'd0) begin
			n_idx = '0;
		end else if (32'(joint_pairs_q) > twik_pkg::MAX_JOINT_PAIRS) begin
			n_idx = twik_pkg::JP_IW'(twik_pkg::MAX_JOINT_PAIRS - 1);
		end else begin
			n_idx = twik_pkg::JP_IW'(joint_pairs_q - 5'd1);
		end
	end

	assign n_val = twik_pkg::NW'(n_idx) + twik_pkg::NW'(1);

	// 2*R*n, refreshed every cycle; used late in the pipe
	always_ff @(posedge clk) begin
		scale_q <= twik_pkg::SCALE_W'({segment_arc_q, 1'b0}) * twik_pkg::SCALE_W'(n_val);
	end

	// Global advance: every stage moves when the output slot is free or being taken.
	assign en          = !vld_q[twik_pkg::PIPE_DEPTH-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[twik_pkg::PIPE_DEPTH-2:0], in_ch.valid};
		end
	end

	// half joint angles, valid at stage 4
	twik_angle u_pan (
		.clk        (clk),
		.en         (en),
		.angle      (in_ch.pan_angle),
		.bend_limit (bend_limit_q),
		.n_idx      (n_idx),
		.th         (th_p)
	);

	twik_angle u_tilt (
		.clk        (clk),
		.en         (en),
		.angle      (in_ch.tilt_angle),
		.bend_limit (bend_limit_q),
		.n_idx      (n_idx),
		.th         (th_t)
	);

	// Seven cosine lanes run in lockstep: alpha, alpha -/+ pan, alpha -/+ tilt,
	// and the two cross terms.
	assign alpha = signed'({3'b000, wire_angle_q, 14'd0});

	twik_cos u_cos_a (.clk(clk), .en(en), .arg(alpha), .cos_val(c_a));
	twik_cos u_cos_e (.clk(clk), .en(en), .arg(alpha - 34'(th_p)), .cos_val(c_e));
	twik_cos u_cos_w (.clk(clk), .en(en), .arg(alpha + 34'(th_p)), .cos_val(c_w));
	twik_cos u_cos_s (.clk(clk), .en(en), .arg(alpha - 34'(th_t)), .cos_val(c_s));
	twik_cos u_cos_n (.clk(clk), .en(en), .arg(alpha + 34'(th_t)), .cos_val(c_n));
	twik_cos u_cos_p (.clk(clk), .en(en), .arg(34'(th_p)), .cos_val(c_p));
	twik_cos u_cos_t (.clk(clk), .en(en), .arg(34'(th_t)), .cos_val(c_t));

	// wire lengths land in the output register at the last stage
	twik_wire u_east (.clk(clk), .en(en), .cos_a(c_a), .cos_main(c_e), .cos_cross(c_t),
		.scale(scale_q), .len(out_ch.east_length));
	twik_wire u_west (.clk(clk), .en(en), .cos_a(c_a), .cos_main(c_w), .cos_cross(c_t),
		.scale(scale_q), .len(out_ch.west_length));
	twik_wire u_south (.clk(clk), .en(en), .cos_a(c_a), .cos_main(c_s), .cos_cross(c_p),
		.scale(scale_q), .len(out_ch.south_length));
	twik_wire u_north (.clk(clk), .en(en), .cos_a(c_a), .cos_main(c_n), .cos_cross(c_p),
		.scale(scale_q), .len(out_ch.north_length));

	// Grip: difference, product, round in three stages, then delay to line up
	// with the wire lengths.
	always_ff @(posedge clk) begin
		if (en) begin
			gdiff_s1 <= signed'({2'b00, forceps_max_q}) - 18'(in_ch.grip_angle);
			gprod_s2 <= 35'(gdiff_s1) * 35'(signed'({1'b0, grip_gain_q}));
			grip_s3  <= twik_pkg::rnd_sat(64'(gprod_s2), 8);
			grip_dly[0] <= grip_s3;
			for (int i = 1; i < int'(twik_pkg::GRIP_DLY); i++) begin
				grip_dly[i] <= grip_dly[i-1];
			end
		end
	end

	assign out_ch.grip_length = grip_dly[twik_pkg::GRIP_DLY-1];
	assign out_ch.valid       = vld_q[twik_pkg::PIPE_DEPTH-1];
endmodule

// ===== rtl/twik_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the tendon wire length IK top, attached by bind.
// Depends on tendon_wire_length_ik_top port names and twik_pkg register codes.
module twik_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] east_length,
	input logic [23:0] grip_length,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(east_length) && $stable(grip_length))
		else $error("result changed while stalled");

	// an empty output slot never blocks a request
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with empty output");

	// a stalled output blocks new requests
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken during output stall");

	// grip gain reads back what was written
	a_gain_rb: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) &&
		$past(psel && penable && pwrite && paddr[4:2] == twik_pkg::REG_GRIP_GAIN) &&
		paddr[4:2] == twik_pkg::REG_GRIP_GAIN |-> prdata[15:0] == $past(pwdata[15:0]))
		else $error("grip gain readback mismatch");
endmodule

bind tendon_wire_length_ik_top twik_checker u_twik_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.east_length (out_ch.east_length),
	.grip_length (out_ch.grip_length),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);

// ===== verif/tendon_wire_length_ik_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking tendon wire length IK bench: directed table, extreme settings, random requests.
// Depends on twik_pkg, twik_if and the block's RTL; predicts lengths with its own fixed-point math.
module tendon_wire_length_ik_top_tb;

	typedef struct packed {
		logic signed [23:0] east;
		logic signed [23:0] west;
		logic signed [23:0] south;
		logic signed [23:0] north;
		logic signed [23:0] grip;
	} lengths_t;

	typedef struct {
		logic [16:0] pan;
		logic [16:0] tilt;
		logic [16:0] grip;
		bit          known;
		lengths_t    want;
	} angle_row_t;

	localparam longint unsigned PI_C     = 64'd3373259426;
	localparam longint unsigned HALF_PI_C = 64'd1686629713;
	localparam longint unsigned TWO_PI_C = 64'd6746518852;
	localparam longint          ONE_C    = 64'sd1073741824;
	localparam longint unsigned RAD_C    = 64'd1199381129;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [twik_pkg::ADDR_W-1:0] paddr = '0;
	logic [twik_pkg::DATA_W-1:0] pwdata = '0;
	logic [twik_pkg::DATA_W-1:0] prdata;
	logic pready;

	twik_in_if  in_ch();
	twik_out_if out_ch();

	tendon_wire_length_ik_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow copy of the register file
	logic [15:0] bend_lim_q, forceps_q, gain_q;
	logic [4:0]  pairs_q;
	logic [19:0] arc_q;
	logic [16:0] alpha_q;

	lengths_t expected_lengths[$];
	int  errors = 0;
	bit  hold_off = 1'b0;
	bit  stim_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint cos_fx(longint x);
		longint unsigned u, x2, tt, p;
		longint t;
		bit neg;
		longint unsigned dv [6];
		dv = '{132, 90, 56, 30, 12, 2};
		u = abs64(x) % TWO_PI_C;
		neg = 1'b0;
		t = ONE_C;
		if (u > PI_C) u = TWO_PI_C - u;
		if (u > HALF_PI_C) begin
			neg = 1'b1;
			u = PI_C - u;
		end
		x2 = (u * u) >> 30;
		for (int i = 0; i < 6; i++) begin
			tt = t < 0 ? 0 : t;
			p = (x2 * tt) >> 30;
			t = ONE_C - longint'(p / dv[i]);
		end
		return neg ? -t : t;
	endfunction

	function automatic longint half_angle(longint deg, longint unsigned n);
		longint unsigned q;
		q = (abs64(deg) * RAD_C) / ((64'd2 * n) << 14);
		return deg < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [23:0] round_clip(longint v, int sh);
		longint unsigned m;
		m = (abs64(v) + (64'd1 << (sh - 1))) >> sh;
		if (v < 0) begin
			if (m > 64'd8388608) m = 64'd8388608;
			return 24'(-longint'(m));
		end
		if (m > 64'd8388607) m = 64'd8388607;
		return 24'(m);
	endfunction

	function automatic lengths_t predict_lengths(logic signed [16:0] pan_in,
		logic signed [16:0] tilt_in, logic signed [16:0] grip_in);
		longint lim, pan, tilt, thp, tht, alpha, ca, scale;
		longint unsigned n;
		lengths_t r;
		lim = bend_lim_q;
		pan = pan_in;
		tilt = tilt_in;
		n = pairs_q;
		if (n == 0) n = 1;
		if (n > twik_pkg::MAX_JOINT_PAIRS) n = twik_pkg::MAX_JOINT_PAIRS;
		if (pan > lim) pan = lim;
		if (pan < -lim) pan = -lim;
		if (tilt > lim) tilt = lim;
		if (tilt < -lim) tilt = -lim;
		thp = half_angle(pan, n);
		tht = half_angle(tilt, n);
		alpha = longint'(alpha_q) << 14;
		ca = cos_fx(alpha);
		scale = 2 * longint'(arc_q) * longint'(n);
		r.east  = round_clip(scale * (ca - cos_fx(alpha - thp) + ONE_C - cos_fx(tht)), 30);
		r.west  = round_clip(scale * (ca - cos_fx(alpha + thp) + ONE_C - cos_fx(tht)), 30);
		r.south = round_clip(scale * (ca - cos_fx(alpha - tht) + ONE_C - cos_fx(thp)), 30);
		r.north = round_clip(scale * (ca - cos_fx(alpha + tht) + ONE_C - cos_fx(thp)), 30);
		r.grip  = round_clip((longint'(forceps_q) - longint'(grip_in)) * longint'(gain_q), 8);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic signed [23:0] got,
		logic signed [23:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// APB write: setup then access; mirror the register in the shadow copy
	task automatic write_reg(twik_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= twik_pkg::ADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			twik_pkg::REG_BEND_LIMIT:  bend_lim_q = val[15:0];
			twik_pkg::REG_JOINT_PAIRS: pairs_q = val[4:0];
			twik_pkg::REG_SEGMENT_ARC: arc_q = val[19:0];
			twik_pkg::REG_WIRE_ANGLE:  alpha_q = val[16:0];
			twik_pkg::REG_FORCEPS_MAX: forceps_q = val[15:0];
			twik_pkg::REG_GRIP_GAIN:   gain_q = val[15:0];
			default: ;
		endcase
	endtask

	// gap length: mostly short, a few long
	function automatic int gap_len();
		int k;
		k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0) k = 0;
		return k;
	endfunction

	// offer one request and hold it until accepted; record its prediction
	task automatic send_angles(logic [16:0] pan, logic [16:0] tilt, logic [16:0] grip,
		bit known, lengths_t want);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.pan_angle <= pan;
		in_ch.tilt_angle <= tilt;
		in_ch.grip_angle <= grip;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_lengths.insert(expected_lengths.size(),
			known ? want : predict_lengths(pan, tilt, grip));
		gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_lengths.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [16:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 17'($urandom_range(0, 1) ? 46080 : -46080);
			1: return 17'($urandom);
			2: return 17'($signed($urandom_range(0, 512)) - 256);
			default: return 17'($signed($urandom_range(0, 92160)) - 46080);
		endcase
	endfunction

	// result side: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_lengths.size() == 0) begin
					report_mismatch("unexpected result", out_ch.east_length, '0);
				end else begin
					lengths_t w;
					w = expected_lengths.pop_front();
					if (out_ch.east_length !== w.east)
						report_mismatch("east", out_ch.east_length, w.east);
					if (out_ch.west_length !== w.west)
						report_mismatch("west", out_ch.west_length, w.west);
					if (out_ch.south_length !== w.south)
						report_mismatch("south", out_ch.south_length, w.south);
					if (out_ch.north_length !== w.north)
						report_mismatch("north", out_ch.north_length, w.north);
					if (out_ch.grip_length !== w.grip)
						report_mismatch("grip", out_ch.grip_length, w.grip);
				end
			end
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end else if (stim_done || $urandom_range(0, 2) != 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				if ($urandom_range(0, 19) == 0)
					repeat ($urandom_range(5, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		angle_row_t rows[$];
		angle_row_t r;
		lengths_t zero_len;
		zero_len = '0;
		in_ch.valid = 1'b0;
		in_ch.pan_angle = '0;
		in_ch.tilt_angle = '0;
		in_ch.grip_angle = '0;
		bend_lim_q = twik_pkg::RST_BEND_LIMIT; pairs_q = twik_pkg::RST_JOINT_PAIRS;
		arc_q = twik_pkg::RST_SEGMENT_ARC; alpha_q = twik_pkg::RST_WIRE_ANGLE;
		forceps_q = twik_pkg::RST_FORCEPS_MAX; gain_q = twik_pkg::RST_GRIP_GAIN;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table; zero angles with zero alpha and zero gain give all zeros
		r = '{17'd0, 17'd0, 17'd0, 1'b1, zero_len};
		rows.insert(rows.size(), r);
		r = '{17'd46080, 17'd0, 17'd0, 1'b0, zero_len}; rows.insert(rows.size(), r);
		r = '{-17'sd46080, 17'd0, 17'd0, 1'b0, zero_len}; rows.insert(rows.size(), r);
		r = '{17'd0, 17'd46080, 17'd0, 1'b0, zero_len}; rows.insert(rows.size(), r);
		r = '{17'd0, -17'sd46080, 17'd0, 1'b0, zero_len}; rows.insert(rows.size(), r);
		r = '{17'h0FFFF, 17'h10000, 17'h0FFFF, 1'b0, zero_len}; rows.insert(rows.size(), r);
		r = '{17'h10000, 17'h0FFFF, 17'h10000, 1'b0, zero_len}; rows.insert(rows.size(), r);
		r = '{17'd1, -17'sd1, 17'd23040, 1'b0, zero_len}; rows.insert(rows.size(), r);
		foreach (rows[i]) send_angles(rows[i].pan, rows[i].tilt, rows[i].grip,
			rows[i].known, rows[i].want);
		drain();

		// extreme settings, including out-of-range pair counts and saturation
		write_reg(twik_pkg::REG_GRIP_GAIN, 32'd65535);
		write_reg(twik_pkg::REG_FORCEPS_MAX, 32'd46080);
		write_reg(twik_pkg::REG_SEGMENT_ARC, 32'hFFFFF);
		write_reg(twik_pkg::REG_WIRE_ANGLE, 32'd102944);
		write_reg(twik_pkg::REG_JOINT_PAIRS, 32'd0);
		write_reg(twik_pkg::REG_BEND_LIMIT, 32'hFFFF);
		foreach (rows[i]) send_angles(rows[i].pan, rows[i].tilt, rows[i].grip, 1'b0, zero_len);
		drain();
		write_reg(twik_pkg::REG_JOINT_PAIRS, 32'd31);
		write_reg(twik_pkg::REG_WIRE_ANGLE, 32'h1FFFF);
		write_reg(twik_pkg::REG_BEND_LIMIT, 32'd0);
		write_reg(twik_pkg::REG_FORCEPS_MAX, 32'hFFFF);
		foreach (rows[i]) send_angles(rows[i].pan, rows[i].tilt, rows[i].grip, 1'b0, zero_len);
		drain();

		// random phases, each under a new setting
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(twik_pkg::REG_BEND_LIMIT,
				$urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 46080));
			write_reg(twik_pkg::REG_JOINT_PAIRS, $urandom_range(0, 31));
			write_reg(twik_pkg::REG_SEGMENT_ARC, $urandom_range(0, 1048575));
			write_reg(twik_pkg::REG_WIRE_ANGLE,
				$urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 102944));
			write_reg(twik_pkg::REG_FORCEPS_MAX, $urandom_range(0, 65535));
			write_reg(twik_pkg::REG_GRIP_GAIN, $urandom_range(0, 65535));
			if (ph == 3) hold_off = 1'b1;
			for (int k = 0; k < 50; k++)
				send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0, zero_len);
			drain();
		end

		stim_done = 1'b1;
		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
